/* src/eoah_pkg.sv */
// eoah_pkg: payload structs, protocol constants and controller/datapath
// command and status types for the encryption-ordered ACL hold block.
// No dependencies.
`default_nettype none
package eoah_pkg;

  typedef struct packed {
    logic [7:0]  packet_kind;
    logic [11:0] packet_length;
    logic [7:0]  event_code;
    logic [7:0]  status_or_subevent;
    logic [15:0] event_handle;
    logic [7:0]  enable_byte;
    logic [15:0] acl_header;
    logic [15:0] packet_tag;
    logic        host_accepted;
  } pkt_t;

  typedef struct packed {
    logic [15:0] out_tag;
    logic        action;
    logic        last;
  } res_t;

  localparam logic [7:0]  KIND_ACL        = 8'h02;
  localparam logic [7:0]  KIND_EVT        = 8'h04;
  localparam logic [7:0]  EVT_LE_META     = 8'h3E;
  localparam logic [7:0]  SUB_LTK_REQ     = 8'h05;
  localparam logic [7:0]  EVT_ENC_CHANGE  = 8'h08;
  localparam logic [7:0]  EVT_DISCONN     = 8'h05;
  localparam logic [7:0]  STATUS_SUCCESS  = 8'h00;
  localparam logic        ACT_DELIVER     = 1'b0;
  localparam logic        ACT_DISCARD     = 1'b1;
  localparam logic [15:0] NO_HANDLE       = 16'hFFFF;
  localparam logic [15:0] ACL_HANDLE_MASK = 16'h0FFF;
  localparam logic [11:0] MIN_LEN_EVT     = 12'd3;
  localparam logic [11:0] MIN_LEN_ACL     = 12'd5;
  localparam logic [11:0] MIN_LEN_LTK     = 12'd6;
  localparam logic [11:0] MIN_LEN_HANDLE  = 12'd7;

  typedef enum logic [2:0] {
    CLS_PASS,
    CLS_LTK,
    CLS_ENC,
    CLS_DISC,
    CLS_ACL
  } cls_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_TAG,
    ST_POST_DLV,
    ST_POST_DSC
  } state_t;

  typedef enum logic [1:0] {
    SRC_TAG,
    SRC_NEWEST,
    SRC_OLDEST
  } src_t;

  typedef enum logic [1:0] {
    WATCH_KEEP,
    WATCH_SET,
    WATCH_CLEAR
  } watch_t;

  typedef struct packed {
    logic   latch;
    logic   hold;
    logic   load;
    src_t   src;
    logic   act;
    logic   last;
    logic   cnt_dec;
    logic   cnt_clr;
    logic   rd_inc;
    watch_t watch;
  } cmd_t;

  typedef struct packed {
    cls_t cls_in;
    cls_t cls;
    logic success;
    logic cnt_zero;
    logic cnt_one;
    logic full;
    logic rd_last;
    logic can_load;
  } sts_t;

endpackage
`default_nettype wire

/* src/encryption_ordered_acl_hold.sv */
// Encryption-ordered ACL hold, top level: joins eoah_ctrl and eoah_dp.
// Depends on eoah_pkg, eoah_ctrl, eoah_dp.
//
// One H4 packet header beat is taken while the block is idle. An ACL beat
// on the watched handle that fits in the store is held and gives no
// result. Any other beat gives n result beats, n from 1 to HOLD_DEPTH + 1;
// the result register emits one beat per cycle when the result side does
// not stall. The next packet is taken once the last result of the current
// one sits in the result register.
`default_nettype none
module encryption_ordered_acl_hold #(
  parameter int HOLD_DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           pkt_valid,
  output logic                pkt_stall,
  input  wire eoah_pkg::pkt_t pkt,
  output logic                res_valid,
  input  wire logic           res_stall,
  output eoah_pkg::res_t      res
);
  import eoah_pkg::*;

  cmd_t cmd;
  sts_t sts;

  eoah_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  eoah_dp #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // block stays busy until the last beat of a packet is in the result register
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> pkt_stall)
    else $error("non-final result visible while block accepts input");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.can_load)
    else $error("result register overwritten while stalled");

  a_hold_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.hold |-> !sts.full)
    else $error("tag held into a full store");

endmodule
`default_nettype wire

/* src/eoah_ctrl.sv */
// eoah_ctrl: sequencing state machine; issues one result beat per cycle while the result register can load.
// Depends on eoah_pkg.
`default_nettype none
module eoah_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pkt_valid,
  output logic               pkt_stall,
  input  wire eoah_pkg::sts_t sts,
  output eoah_pkg::cmd_t     cmd
);
  import eoah_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.src    = SRC_TAG;
    cmd.watch  = WATCH_KEEP;
    pkt_stall  = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (pkt_valid) begin
          cmd.latch = 1'b1;
          unique case (sts.cls_in) inside
            CLS_ACL: begin
              if (sts.full) begin
                state_next = ST_TAG;
              end else begin
                cmd.hold = 1'b1;
              end
            end
            CLS_LTK, CLS_DISC: begin
              state_next = sts.cnt_zero ? ST_TAG : ST_PRE;
            end
            default: begin
              state_next = ST_TAG;
            end
          endcase
        end
      end
      ST_PRE: begin
        if (sts.can_load) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_NEWEST;
          cmd.act     = ACT_DISCARD;
          cmd.cnt_dec = 1'b1;
          if (sts.cnt_one) begin
            state_next = ST_TAG;
          end
        end
      end
      ST_TAG: begin
        if (sts.can_load) begin
          cmd.load = 1'b1;
          cmd.act  = (sts.cls == CLS_ACL) ? ACT_DISCARD : ACT_DELIVER;
          cmd.last = !((sts.cls == CLS_ENC) && !sts.cnt_zero);
          unique case (sts.cls) inside
            CLS_LTK:           cmd.watch = WATCH_SET;
            CLS_ENC, CLS_DISC: cmd.watch = WATCH_CLEAR;
            default:           cmd.watch = WATCH_KEEP;
          endcase
          if ((sts.cls == CLS_ENC) && !sts.cnt_zero) begin
            state_next = sts.success ? ST_POST_DLV : ST_POST_DSC;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_POST_DLV: begin
        if (sts.can_load) begin
          cmd.load   = 1'b1;
          cmd.src    = SRC_OLDEST;
          cmd.act    = ACT_DELIVER;
          cmd.last   = sts.rd_last;
          cmd.rd_inc = 1'b1;
          if (sts.rd_last) begin
            cmd.cnt_clr = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      ST_POST_DSC: begin
        if (sts.can_load) begin
          cmd.load    = 1'b1;
          cmd.src     = SRC_NEWEST;
          cmd.act     = ACT_DISCARD;
          cmd.last    = sts.cnt_one;
          cmd.cnt_dec = 1'b1;
          if (sts.cnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/eoah_dp.sv */
// eoah_dp: packet decode, watched handle, held tag store and result register.
// Depends on eoah_pkg; driven by eoah_ctrl commands.
`default_nettype none
module eoah_dp #(
  parameter int HOLD_DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire eoah_pkg::pkt_t pkt,
  input  wire eoah_pkg::cmd_t cmd,
  output eoah_pkg::sts_t      sts,
  output logic                res_valid,
  input  wire logic           res_stall,
  output eoah_pkg::res_t      res
);
  import eoah_pkg::*;

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

  logic [15:0]   watched;
  logic [15:0]   held [HOLD_DEPTH];
  logic [CW-1:0] cnt;
  logic [IW-1:0] rd_ptr;
  logic [15:0]   tag_q;
  logic [15:0]   handle_q;
  cls_t          cls_q;
  logic          success_q;

  logic          is_evt;
  logic          handle_hit;
  cls_t          cls_in;
  logic          success_in;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] rd_idx;
  logic [15:0]   sel_tag;

  always_comb begin
    is_evt     = (pkt.packet_kind == KIND_EVT) && (pkt.packet_length >= MIN_LEN_EVT);
    handle_hit = (pkt.event_handle == watched);
    success_in = (pkt.status_or_subevent == STATUS_SUCCESS) &&
                 (pkt.enable_byte != 8'd0) && pkt.host_accepted;
    cls_in     = CLS_PASS;
    if (is_evt) begin
      if ((pkt.event_code == EVT_LE_META) && (pkt.packet_length >= MIN_LEN_LTK) &&
          (pkt.status_or_subevent == SUB_LTK_REQ)) begin
        cls_in = CLS_LTK;
      end else if ((pkt.event_code == EVT_ENC_CHANGE) &&
                   (pkt.packet_length >= MIN_LEN_HANDLE) && handle_hit) begin
        cls_in = CLS_ENC;
      end else if ((pkt.event_code == EVT_DISCONN) &&
                   (pkt.packet_length >= MIN_LEN_HANDLE) && handle_hit) begin
        cls_in = CLS_DISC;
      end
    end else if ((pkt.packet_kind == KIND_ACL) && (pkt.packet_length >= MIN_LEN_ACL) &&
                 ((pkt.acl_header & ACL_HANDLE_MASK) == watched)) begin
      cls_in = CLS_ACL;
    end
  end

  assign cnt_m1 = cnt - CW'(1);
  assign rd_idx = (cmd.src == SRC_OLDEST) ? rd_ptr : cnt_m1[IW-1:0];
  assign sel_tag = (cmd.src == SRC_TAG) ? tag_q : held[rd_idx];

  always_comb begin
    sts.cls_in   = cls_in;
    sts.cls      = cls_q;
    sts.success  = success_q;
    sts.cnt_zero = (cnt == '0);
    sts.cnt_one  = (cnt == CW'(1));
    sts.full     = (cnt == CW'(HOLD_DEPTH));
    sts.rd_last  = ((CW'(rd_ptr) + CW'(1)) == cnt);
    sts.can_load = !res_valid || !res_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      watched   <= NO_HANDLE;
      cnt       <= '0;
      rd_ptr    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.hold) begin
        cnt <= cnt + CW'(1);
      end else if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_dec) begin
        cnt <= cnt_m1;
      end
      if (cmd.latch) begin
        rd_ptr <= '0;
      end else if (cmd.rd_inc) begin
        rd_ptr <= rd_ptr + IW'(1);
      end
      unique case (cmd.watch)
        WATCH_SET:   watched <= handle_q;
        WATCH_CLEAR: watched <= NO_HANDLE;
        default:     watched <= watched;
      endcase
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tag_q     <= pkt.packet_tag;
      handle_q  <= pkt.event_handle;
      cls_q     <= cls_in;
      success_q <= success_in;
    end
    if (cmd.hold) begin
      held[cnt[IW-1:0]] <= pkt.packet_tag;
    end
    if (cmd.load) begin
      res.out_tag <= sel_tag;
      res.action  <= cmd.act;
      res.last    <= cmd.last;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_encryption_ordered_acl_hold.sv */
// tb_encryption_ordered_acl_hold: directed table plus random H4 header beats,
// scoreboarded against a behavioral model of the ACL hold store and watch.
// Depends on eoah_pkg and encryption_ordered_acl_hold.
module tb_encryption_ordered_acl_hold;
  timeunit 1ns;
  timeprecision 1ps;
  import eoah_pkg::*;

  localparam int HOLD_DEPTH = 4;
  localparam int N_RANDOM = 343;

  typedef struct packed {
    pkt_t p;
    logic typed;
    res_t exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pkt_valid = 1'b0;
  logic pkt_stall;
  pkt_t pkt = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  // model state
  logic [15:0] watch_hdl = NO_HANDLE;
  logic [15:0] held [HOLD_DEPTH];
  int held_cnt = 0;

  res_t step_acts[$];
  res_t pending_actions[$];
  row_t dir_rows[$];
  res_t want;
  int errors = 0;
  int snd_idle = 13;
  int rcv_stall = 60;

  encryption_ordered_acl_hold #(.HOLD_DEPTH(HOLD_DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .pkt_valid(pkt_valid),
    .pkt_stall(pkt_stall),
    .pkt(pkt),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("encryption_ordered_acl_hold verification failed");
    $finish;
  end

  task automatic note_action(input logic [15:0] tag, input logic act);
    step_acts.push_back('{tag, act, 1'b0});
  endtask

  task automatic drop_held();
    while (held_cnt > 0) begin
      held_cnt--;
      note_action(held[held_cnt], ACT_DISCARD);
    end
    watch_hdl = NO_HANDLE;
  endtask

  task automatic predict_actions(input pkt_t p);
    logic complete;
    logic success;
    int i;
    complete = 1'b0;
    success = 1'b0;
    step_acts.delete();
    if (p.packet_length >= MIN_LEN_EVT && p.packet_kind == KIND_EVT) begin
      if (p.event_code == EVT_LE_META && p.packet_length >= MIN_LEN_LTK &&
          p.status_or_subevent == SUB_LTK_REQ) begin
        drop_held();
        watch_hdl = p.event_handle;
      end else if (p.event_code == EVT_ENC_CHANGE && p.packet_length >= MIN_LEN_HANDLE &&
                   p.event_handle == watch_hdl) begin
        complete = 1'b1;
        success = (p.status_or_subevent == STATUS_SUCCESS) && (p.enable_byte != 8'h00);
      end else if (p.event_code == EVT_DISCONN && p.packet_length >= MIN_LEN_HANDLE &&
                   p.event_handle == watch_hdl) begin
        drop_held();
      end
      note_action(p.packet_tag, ACT_DELIVER);
      if (complete) begin
        if (success && p.host_accepted) begin
          for (i = 0; i < held_cnt; i++) note_action(held[i], ACT_DELIVER);
          held_cnt = 0;
          watch_hdl = NO_HANDLE;
        end else begin
          drop_held();
        end
      end
    end else if (p.packet_length >= MIN_LEN_ACL && p.packet_kind == KIND_ACL &&
                 (p.acl_header & ACL_HANDLE_MASK) == watch_hdl) begin
      if (held_cnt < HOLD_DEPTH) begin
        held[held_cnt] = p.packet_tag;
        held_cnt++;
      end else begin
        note_action(p.packet_tag, ACT_DISCARD);
      end
    end else begin
      note_action(p.packet_tag, ACT_DELIVER);
    end
  endtask

  function automatic row_t mk_row(input logic [7:0] kind, input logic [11:0] len,
                                  input logic [7:0] code, input logic [7:0] sub,
                                  input logic [15:0] eh, input logic [7:0] en,
                                  input logic [15:0] acl, input logic [15:0] tag,
                                  input logic acc, input logic typed, input logic act);
    row_t r;
    r.p = '{kind, len, code, sub, eh, en, acl, tag, acc};
    r.typed = typed;
    r.exp = '{tag, act, 1'b1};
    return r;
  endfunction

  function automatic logic [11:0] pick_len(input logic [11:0] lo);
    int s;
    s = $urandom_range(0, 19);
    if (s < 12) return lo;
    if (s < 17) return 12'($urandom_range(int'(lo), 4095));
    return 12'($urandom_range(0, int'(lo) - 1));
  endfunction

  function automatic logic [15:0] pick_handle();
    if ($urandom_range(0, 4) != 0) return watch_hdl;
    return 16'($urandom_range(0, 3));
  endfunction

  function automatic pkt_t next_packet();
    pkt_t p;
    int sel;
    p.packet_kind = 8'($urandom);
    p.packet_length = 12'($urandom);
    p.event_code = 8'($urandom);
    p.status_or_subevent = 8'($urandom);
    p.event_handle = 16'($urandom);
    p.enable_byte = 8'($urandom);
    p.acl_header = 16'($urandom);
    p.packet_tag = 16'($urandom);
    p.host_accepted = ($urandom_range(0, 3) != 0);
    sel = $urandom_range(0, 99);
    if (sel < 14) begin
      p.packet_kind = KIND_EVT;
      p.event_code = EVT_LE_META;
      p.packet_length = pick_len(MIN_LEN_LTK);
      if ($urandom_range(0, 9) != 0) p.status_or_subevent = SUB_LTK_REQ;
      case ($urandom_range(0, 5))
        4: p.event_handle = 16'h0FFF;
        5: p.event_handle = 16'($urandom);
        default: p.event_handle = 16'($urandom_range(0, 3));
      endcase
    end else if (sel < 50) begin
      p.packet_kind = KIND_ACL;
      p.packet_length = pick_len(MIN_LEN_ACL);
      if ($urandom_range(0, 19) < 17)
        p.acl_header = {4'($urandom), watch_hdl[11:0]};
      else
        p.acl_header = {4'($urandom), 12'($urandom_range(0, 3))};
    end else if (sel < 64) begin
      p.packet_kind = KIND_EVT;
      p.event_code = EVT_ENC_CHANGE;
      p.packet_length = pick_len(MIN_LEN_HANDLE);
      p.event_handle = pick_handle();
      if ($urandom_range(0, 9) < 7) p.status_or_subevent = STATUS_SUCCESS;
      if ($urandom_range(0, 4) != 0) p.enable_byte = 8'($urandom_range(1, 255));
      else p.enable_byte = 8'h00;
    end else if (sel < 72) begin
      p.packet_kind = KIND_EVT;
      p.event_code = EVT_DISCONN;
      p.packet_length = pick_len(MIN_LEN_HANDLE);
      p.event_handle = pick_handle();
    end else if (sel < 80) begin
      p.packet_kind = KIND_EVT;
    end else if (sel < 86) begin
      p.packet_kind = KIND_ACL;
    end
    return p;
  endfunction

  // result side: scoreboard and receiver stalls
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pending_actions.size() == 0) begin
        errors++;
        $display("%0t: mismatch expected no beat, got tag=%h action=%b last=%b",
                 $time, res.out_tag, res.action, res.last);
      end else begin
        want = pending_actions.pop_front();
        if (res.out_tag !== want.out_tag || res.action !== want.action ||
            res.last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected tag=%h action=%b last=%b, %s tag=%h action=%b last=%b",
                   $time, want.out_tag, want.action, want.last, "got",
                   res.out_tag, res.action, res.last);
        end
      end
    end
    res_stall <= ($urandom_range(0, 99) < rcv_stall);
  end

  initial begin
    pkt_t p;
    res_t act;
    int n;
    int i;
    int total;
    int n_dir;

    dir_rows.push_back(mk_row(8'h00, 12'd0, 8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000,
                              16'h0000, 1'b0, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(8'hFF, 12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF,
                              16'hFFFF, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0FFF, 16'h0003, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, 12'd4, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0040, 16'h0004, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, 12'd2, EVT_LE_META, SUB_LTK_REQ, 16'h0040, 8'h00,
                              16'h0040, 16'h0005, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, 12'd5, EVT_LE_META, SUB_LTK_REQ, 16'h0040, 8'h00,
                              16'h0000, 16'h0006, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_LTK, EVT_LE_META, SUB_LTK_REQ, 16'h0040,
                              8'h00, 16'h0000, 16'h0007, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'hF040, 16'hA001, 1'b0, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h1040, 16'hA002, 1'b0, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h2040, 16'hA003, 1'b0, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h3040, 16'hA004, 1'b0, 1'b0, ACT_DELIVER));
    // store full
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0040, 16'hA005, 1'b1, 1'b1, ACT_DISCARD));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_HANDLE, EVT_ENC_CHANGE, STATUS_SUCCESS,
                              16'h0041, 8'h01, 16'h0000, 16'h000D, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, 12'd6, EVT_ENC_CHANGE, STATUS_SUCCESS,
                              16'h0040, 8'h01, 16'h0000, 16'h000E, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_HANDLE, EVT_ENC_CHANGE, STATUS_SUCCESS,
                              16'h0040, 8'h01, 16'h0000, 16'h000F, 1'b1, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_LTK, EVT_LE_META, SUB_LTK_REQ, 16'h0FFF,
                              8'h00, 16'h0000, 16'h0010, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'hFFFF, 16'hB001, 1'b1, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'hCFFF, 16'hB002, 1'b1, 1'b0, ACT_DELIVER));
    // success but host refused
    dir_rows.push_back(mk_row(KIND_EVT, 12'hFFF, EVT_ENC_CHANGE, STATUS_SUCCESS, 16'h0FFF,
                              8'hFF, 16'h0000, 16'h0013, 1'b0, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_LTK, EVT_LE_META, SUB_LTK_REQ, 16'h0123,
                              8'h00, 16'h0000, 16'h0014, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, 12'hFFF, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0123, 16'hC001, 1'b1, 1'b0, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_HANDLE, EVT_DISCONN, 8'h00, 16'h0123,
                              8'h00, 16'h0000, 16'h0016, 1'b1, 1'b0, ACT_DELIVER));
    // watched handle above 12 bits never matches an ACL
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_LTK, EVT_LE_META, SUB_LTK_REQ, 16'h8123,
                              8'h00, 16'h0000, 16'h0017, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0123, 16'h0018, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_LTK, EVT_LE_META, SUB_LTK_REQ, 16'h0123,
                              8'h00, 16'h0000, 16'h0019, 1'b1, 1'b1, ACT_DELIVER));
    dir_rows.push_back(mk_row(KIND_ACL, MIN_LEN_ACL, 8'h00, 8'h00, 16'h0000, 8'h00,
                              16'h0123, 16'hC002, 1'b1, 1'b0, ACT_DELIVER));
    // encryption off
    dir_rows.push_back(mk_row(KIND_EVT, MIN_LEN_HANDLE, EVT_ENC_CHANGE, STATUS_SUCCESS,
                              16'h0123, 8'h00, 16'h0000, 16'h001B, 1'b1, 1'b0, ACT_DELIVER));

    n_dir = dir_rows.size();
    total = n_dir + N_RANDOM;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < total; n++) begin
      if (n == n_dir + N_RANDOM / 3) begin
        snd_idle = 60;
        rcv_stall = 13;
      end else if (n == n_dir + 2 * N_RANDOM / 3) begin
        snd_idle = 0;
        rcv_stall = 0;
      end
      p = (n < n_dir) ? dir_rows[n].p : next_packet();
      while ($urandom_range(0, 99) < snd_idle) begin
        pkt_valid <= 1'b0;
        @(posedge clk);
      end
      pkt <= p;
      pkt_valid <= 1'b1;
      @(posedge clk);
      while (pkt_stall) @(posedge clk);
      predict_actions(p);
      if (n < n_dir && dir_rows[n].typed) begin
        pending_actions.push_back(dir_rows[n].exp);
      end else begin
        for (i = 0; i < step_acts.size(); i++) begin
          act = step_acts[i];
          act.last = (i == step_acts.size() - 1);
          pending_actions.push_back(act);
        end
      end
    end
    pkt_valid <= 1'b0;

    while (pending_actions.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("encryption_ordered_acl_hold verification clean");
    end else begin
      $display("encryption_ordered_acl_hold verification failed");
    end
    $finish;
  end

endmodule
